### sv/dqc_pkg.sv
// Shared types for the deque-with-cursor block: operation codes.
package dqc_pkg;

    // Operation carried in s_tuser
    typedef enum logic [2:0] {
        FUNC_QUERY        = 3'd0,
        FUNC_INSERT_FRONT = 3'd1,
        FUNC_INSERT_BACK  = 3'd2,
        FUNC_REMOVE_FRONT = 3'd3,
        FUNC_REMOVE_BACK  = 3'd4,
        FUNC_CURSOR_FIRST = 3'd5,
        FUNC_CURSOR_LAST  = 3'd6,
        FUNC_ADVANCE      = 3'd7
    } func_t;

    localparam int unsigned WORD_W = 32;

endpackage

### sv/dqc_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module dqc_ram
#(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

### sv/deque_with_cursor.sv
// Deque with cursor: bounded double-ended queue of signed words in a ring, with a read cursor.
//
// Each transaction on the s_ side carries one operation (s_tuser) and a value (s_tdata);
// each one gives exactly one result transaction on the m_ side. Entries live in a ring
// of DEPTH slots held in a two-read-port RAM; head, count and cursor are registers, so
// every end operation and cursor move is a constant-time register update. Throughput is
// one operation per clock cycle sustained while the m_ side takes each result. An
// accepted operation first sits in the input register, then the state update and the
// RAM reads (removed slot and new cursor slot) land in the result register, which
// offers it on the m_ side. Inserts into a full store and removals from an empty list
// return ok=0 and change nothing. Removing from the front parks the cursor on the new
// first entry, from the back on the new last entry; inserts leave the cursor where it
// was. The RAM needs no clearing after reset: data read from a slot that is not live
// is never passed on.
module deque_with_cursor
    import dqc_pkg::*;
#(
    parameter int unsigned DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,

    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [WORD_W-1:0]                      s_tdata,   // [31:0] item_value
    input  logic [2:0]                             s_tuser,   // [2:0] func

    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // from bit 0 up: ok, removed_value(32), current_value(32), is_empty, at_first,
    // at_last, out_of_list, entry_count($clog2(DEPTH+1)), zero fill to a byte
    output logic [((2*WORD_W+5+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata
);

    localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW     = $clog2(DEPTH + 1);
    localparam int unsigned SW     = CW + 1;
    localparam int unsigned DATA_W = ((2*WORD_W + 5 + CW + 7) / 8) * 8;

    typedef struct packed {
        logic          ok;
        logic          rm_ok;     // removed value is valid
        logic          cv;        // cursor on the list
        logic          empty;
        logic          at_first;
        logic          at_last;
        logic [CW-1:0] count;
    } res_meta_t;

    // ring arithmetic helpers
    function automatic logic [AW-1:0] slot_after(input logic [AW-1:0] s);
        slot_after = (s == AW'(DEPTH - 1)) ? '0 : s + AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_before(input logic [AW-1:0] s);
        slot_before = (s == '0) ? AW'(DEPTH - 1) : s - AW'(1);
    endfunction

    // (h + n) mod DEPTH for n <= DEPTH
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] h, input logic [CW-1:0] n);
        logic [SW-1:0] sum;
        sum = SW'(h) + SW'(n);
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        ring_add = sum[AW-1:0];
    endfunction

    // input register
    logic              a_valid_reg;
    func_t             a_func_reg;
    logic [WORD_W-1:0] a_value_reg;

    // list state
    logic [AW-1:0] head_reg,   head_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [AW-1:0] cursor_reg, cursor_next;
    logic          cv_reg,     cv_next;

    // result register (RAM read data registers complete it)
    logic       b_valid_reg;
    res_meta_t  b_meta_reg, b_meta_next;

    logic              en_b;
    logic              a_fire;
    logic [AW-1:0]     tail_slot;
    logic [AW-1:0]     end_slot;
    logic [AW-1:0]     tail_next;
    logic              full;
    logic              empty;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr0;
    logic [WORD_W-1:0] ram_q0;
    logic [WORD_W-1:0] ram_q1;
    logic [WORD_W-1:0] removed_value;
    logic [WORD_W-1:0] current_value;

    // handshake: result register frees when empty or taken; input register when it moves on
    assign en_b     = !b_valid_reg || m_tready;
    assign s_tready = !a_valid_reg || en_b;
    assign a_fire   = a_valid_reg && en_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            a_func_reg  <= func_t'(s_tuser);
            a_value_reg <= s_tdata;
        end
    end

    // ring geometry of the current state
    assign end_slot  = ring_add(head_reg, count_reg);
    assign tail_slot = slot_before(end_slot);
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);

    // operation decode and next state
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        cv_next     = cv_reg;
        ram_we      = 1'b0;
        ram_waddr   = end_slot;
        ram_raddr0  = head_reg;
        b_meta_next = '0;
        b_meta_next.ok = 1'b1;

        unique case (a_func_reg)
            FUNC_INSERT_FRONT:
            begin
                if (full)
                begin
                    b_meta_next.ok = 1'b0;
                end
                else
                begin
                    head_next  = slot_before(head_reg);
                    ram_waddr  = slot_before(head_reg);
                    ram_we     = a_fire;
                    count_next = count_reg + CW'(1);
                end
            end
            FUNC_INSERT_BACK:
            begin
                if (full)
                begin
                    b_meta_next.ok = 1'b0;
                end
                else
                begin
                    ram_waddr  = end_slot;
                    ram_we     = a_fire;
                    count_next = count_reg + CW'(1);
                end
            end
            FUNC_REMOVE_FRONT:
            begin
                if (empty)
                begin
                    b_meta_next.ok = 1'b0;
                end
                else
                begin
                    ram_raddr0        = head_reg;
                    b_meta_next.rm_ok = 1'b1;
                    head_next         = slot_after(head_reg);
                    count_next        = count_reg - CW'(1);
                    cursor_next       = slot_after(head_reg);
                    cv_next           = (count_reg != CW'(1));
                end
            end
            FUNC_REMOVE_BACK:
            begin
                if (empty)
                begin
                    b_meta_next.ok = 1'b0;
                end
                else
                begin
                    ram_raddr0        = tail_slot;
                    b_meta_next.rm_ok = 1'b1;
                    count_next        = count_reg - CW'(1);
                    if (count_reg == CW'(1))
                    begin
                        cv_next     = 1'b0;
                        cursor_next = '0;
                    end
                    else
                    begin
                        cv_next     = 1'b1;
                        cursor_next = slot_before(tail_slot);
                    end
                end
            end
            FUNC_CURSOR_FIRST:
            begin
                cv_next     = !empty;
                cursor_next = empty ? '0 : head_reg;
            end
            FUNC_CURSOR_LAST:
            begin
                cv_next     = !empty;
                cursor_next = empty ? '0 : tail_slot;
            end
            FUNC_ADVANCE:
            begin
                if (cv_reg)
                begin
                    if (empty || cursor_reg == tail_slot)
                    begin
                        cv_next     = 1'b0;
                        cursor_next = '0;
                    end
                    else
                    begin
                        cursor_next = slot_after(cursor_reg);
                    end
                end
            end
            FUNC_QUERY:
            begin
            end
            default:
            begin
            end
        endcase

        // status after the operation
        tail_next            = slot_before(ring_add(head_next, count_next));
        b_meta_next.cv       = cv_next;
        b_meta_next.empty    = (count_next == '0);
        b_meta_next.count    = count_next;
        b_meta_next.at_first = b_meta_next.empty ? !cv_next
                                                 : (cv_next && cursor_next == head_next);
        b_meta_next.at_last  = b_meta_next.empty ? !cv_next
                                                 : (cv_next && cursor_next == tail_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            count_reg   <= '0;
            cursor_reg  <= '0;
            cv_reg      <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_fire)
            begin
                head_reg   <= head_next;
                count_reg  <= count_next;
                cursor_reg <= cursor_next;
                cv_reg     <= cv_next;
            end
            if (en_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            b_meta_reg <= b_meta_next;
        end
    end

    // entry store; port 0 reads the removed slot, port 1 the new cursor slot
    dqc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (a_value_reg),
        .rd_en  (a_fire),
        .raddr0 (ram_raddr0),
        .raddr1 (cursor_next),
        .rdata0 (ram_q0),
        .rdata1 (ram_q1)
    );

    assign removed_value = b_meta_reg.rm_ok ? ram_q0 : '0;
    assign current_value = b_meta_reg.cv    ? ram_q1 : '0;

    assign m_tvalid = b_valid_reg;
    assign m_tdata  = DATA_W'({b_meta_reg.count, !b_meta_reg.cv, b_meta_reg.at_last,
                               b_meta_reg.at_first, b_meta_reg.empty, current_value,
                               removed_value, b_meta_reg.ok});

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above store depth");

    a_slots_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg <= AW'(DEPTH - 1)) && (cursor_reg <= AW'(DEPTH - 1)))
        else $error("ring pointer outside store");

    a_empty_cursor_off: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> !cv_reg)
        else $error("cursor on an empty list");

    a_full_insert_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (a_fire && full && (a_func_reg == FUNC_INSERT_FRONT || a_func_reg == FUNC_INSERT_BACK))
        |=> $stable(count_reg) && $stable(head_reg))
        else $error("insert into full store changed the list");

    a_remove_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (a_fire && !empty
         && (a_func_reg == FUNC_REMOVE_FRONT || a_func_reg == FUNC_REMOVE_BACK))
        |=> cv_reg == (count_reg != '0))
        else $error("cursor not parked after removal");

endmodule

### dv/deque_with_cursor_tb.sv
`timescale 1ns / 1ps
// Testbench for deque_with_cursor: directed and random operations checked against a local deque model.
module deque_with_cursor_tb;
    import dqc_pkg::*;

    // Model ring arithmetic below wraps on 4-bit slots, so depth stays at 16
    localparam int unsigned DEPTH      = 16;
    localparam int unsigned COUNT_W    = $clog2(DEPTH + 1);
    localparam int unsigned M_W        = ((2 * WORD_W + 5 + COUNT_W + 7) / 8) * 8;
    localparam int unsigned MAX_CYCLES = 400000;
    localparam int unsigned MAX_IDLE   = 16;

    // Status of one result transaction as the model sees it
    typedef struct packed {
        logic              ok;
        logic [WORD_W-1:0] removed;
        logic [WORD_W-1:0] current;
        logic              empty;
        logic              at_first;
        logic              at_last;
        logic              off_list;
        logic [COUNT_W-1:0] count;
    } deque_status_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [WORD_W-1:0] s_tdata;
    logic [2:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [M_W-1:0]    m_tdata;

    // Model state
    logic [WORD_W-1:0]  ring_words [DEPTH];
    logic [3:0]         head_slot;
    logic [COUNT_W-1:0] held_count;
    logic [3:0]         cursor_slot;
    logic               cursor_on;

    deque_status_t expected_status_q[$];
    int unsigned   cycle_count;
    int unsigned   error_count;
    bit            idle_on;

    deque_with_cursor #(
        .DEPTH(DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Slot of the last entry; wraps mod 16, also right for a full ring
    function automatic logic [3:0] tail_slot();
        return head_slot + held_count[3:0] - 4'd1;
    endfunction

    // Applies one operation to the model and returns the status it reports
    function automatic deque_status_t deque_apply(func_t op, logic [WORD_W-1:0] value);
        deque_status_t st;
        st         = '0;
        st.ok      = 1'b1;
        case (op)
            FUNC_INSERT_FRONT:
            begin
                if (held_count == DEPTH)
                    st.ok = 1'b0;
                else
                begin
                    head_slot             = head_slot - 4'd1;
                    ring_words[head_slot] = value;
                    held_count            = held_count + COUNT_W'(1);
                end
            end
            FUNC_INSERT_BACK:
            begin
                if (held_count == DEPTH)
                    st.ok = 1'b0;
                else
                begin
                    held_count              = held_count + COUNT_W'(1);
                    ring_words[tail_slot()] = value;
                end
            end
            FUNC_REMOVE_FRONT:
            begin
                if (held_count == 0)
                    st.ok = 1'b0;
                else
                begin
                    st.removed  = ring_words[head_slot];
                    head_slot   = head_slot + 4'd1;
                    held_count  = held_count - COUNT_W'(1);
                    cursor_slot = head_slot;
                    cursor_on   = (held_count != 0);
                end
            end
            FUNC_REMOVE_BACK:
            begin
                if (held_count == 0)
                    st.ok = 1'b0;
                else
                begin
                    st.removed = ring_words[tail_slot()];
                    held_count = held_count - COUNT_W'(1);
                    cursor_on  = (held_count != 0);
                    cursor_slot = cursor_on ? tail_slot() : 4'd0;
                end
            end
            FUNC_CURSOR_FIRST:
            begin
                cursor_on   = (held_count != 0);
                cursor_slot = cursor_on ? head_slot : 4'd0;
            end
            FUNC_CURSOR_LAST:
            begin
                cursor_on   = (held_count != 0);
                cursor_slot = cursor_on ? tail_slot() : 4'd0;
            end
            FUNC_ADVANCE:
            begin
                // stepping past the last entry drops the cursor off the list
                if (cursor_on)
                begin
                    if (held_count == 0 || cursor_slot == tail_slot())
                    begin
                        cursor_on   = 1'b0;
                        cursor_slot = 4'd0;
                    end
                    else
                        cursor_slot = cursor_slot + 4'd1;
                end
            end
            default:
            begin
            end
        endcase
        st.empty    = (held_count == 0);
        st.current  = cursor_on ? ring_words[cursor_slot] : '0;
        // an empty list with the cursor off counts as both at first and at last
        st.at_first = st.empty ? !cursor_on : (cursor_on && cursor_slot == head_slot);
        st.at_last  = st.empty ? !cursor_on : (cursor_on && cursor_slot == tail_slot());
        st.off_list = !cursor_on;
        st.count    = held_count;
        return st;
    endfunction

    // Sends one operation; the expected status is queued once the transaction is accepted
    task automatic send_op(func_t op, logic [WORD_W-1:0] value);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        expected_status_q.push_back(deque_apply(op, value));
    endtask

    task automatic wait_results_drained();
        while (expected_status_q.size() != 0)
            @(posedge clk);
    endtask

    // Mostly random words, with the extremes showing up often
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Weighted pick: percent of inserts, percent of removes, rest cursor moves and queries
    function automatic func_t pick_op(int unsigned insert_pct, int unsigned remove_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < insert_pct)
            return $urandom_range(0, 1) ? FUNC_INSERT_FRONT : FUNC_INSERT_BACK;
        if (r < insert_pct + remove_pct)
            return $urandom_range(0, 1) ? FUNC_REMOVE_FRONT : FUNC_REMOVE_BACK;
        case ($urandom_range(0, 3))
            0:       return FUNC_QUERY;
            1:       return FUNC_CURSOR_FIRST;
            2:       return FUNC_CURSOR_LAST;
            default: return FUNC_ADVANCE;
        endcase
    endfunction

    // Empty-list corners, extreme values, cursor walk off the end, cursor after removals
    task automatic test_directed();
        send_op(FUNC_QUERY,        32'h0000_0000);
        send_op(FUNC_REMOVE_FRONT, 32'hFFFF_FFFF);
        send_op(FUNC_REMOVE_BACK,  32'h0000_0000);
        send_op(FUNC_CURSOR_FIRST, 32'h0000_0000);
        send_op(FUNC_CURSOR_LAST,  32'h0000_0000);
        send_op(FUNC_ADVANCE,      32'h0000_0000);
        send_op(FUNC_INSERT_BACK,  32'h7FFF_FFFF);
        send_op(FUNC_INSERT_FRONT, 32'h8000_0000);
        send_op(FUNC_INSERT_BACK,  32'h0000_0000);
        send_op(FUNC_INSERT_BACK,  32'hFFFF_FFFF);
        send_op(FUNC_CURSOR_FIRST, 32'h0000_0000);
        repeat (5) send_op(FUNC_ADVANCE, 32'h0000_0000);
        send_op(FUNC_CURSOR_LAST,  32'h0000_0000);
        send_op(FUNC_INSERT_FRONT, 32'h0000_0005);
        send_op(FUNC_REMOVE_FRONT, 32'h0000_0000);
        send_op(FUNC_REMOVE_BACK,  32'h0000_0000);
        send_op(FUNC_REMOVE_BACK,  32'h0000_0000);
        send_op(FUNC_REMOVE_FRONT, 32'h0000_0000);
        send_op(FUNC_REMOVE_FRONT, 32'h0000_0000);
    endtask

    // Alternating insert-heavy and remove-heavy blocks: runs into full and empty repeatedly
    task automatic test_fill_drain(int unsigned blocks);
        for (int unsigned b = 0; b < blocks; b++)
            repeat (50)
                if (b % 2 == 0)
                    send_op(pick_op(70, 10), pick_word());
                else
                    send_op(pick_op(10, 70), pick_word());
    endtask

    // Sender holds off until every queued result has come back
    task automatic test_pause_until_idle();
        repeat (20) send_op(pick_op(50, 20), pick_word());
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait_results_drained();
        repeat (20) send_op(pick_op(20, 50), pick_word());
    endtask

    // No gaps on either side: one transaction per cycle
    task automatic test_back_to_back(int unsigned n);
        idle_on = 1'b0;
        repeat (n) send_op(pick_op(40, 30), pick_word());
        idle_on = 1'b1;
    endtask

    // Even mix, with idling re-drawn at random every hundred transactions
    task automatic test_random_mix(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
        begin
            if (i % 100 == 0)
                idle_on = $urandom_range(0, 3) != 0;
            send_op(pick_op(35, 35), pick_word());
        end
        idle_on = 1'b1;
    endtask

    task automatic check_field(string name, logic [WORD_W-1:0] exp, logic [WORD_W-1:0] act);
        if (exp !== act)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp, act);
            error_count++;
        end
    endtask

    // Result side: while idling is on, ready may drop for a random stretch before each transaction
    initial
    begin
        int unsigned stall;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Compare every accepted result with the oldest expectation
    always @(posedge clk)
    begin
        deque_status_t exp;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_status_q.size() == 0)
            begin
                $error("result transaction with nothing expected: %0h", m_tdata);
                error_count++;
            end
            else
            begin
                exp = expected_status_q.pop_front();
                check_field("ok",            WORD_W'(exp.ok),       WORD_W'(m_tdata[0]));
                check_field("removed_value", exp.removed,           m_tdata[32:1]);
                check_field("current_value", exp.current,           m_tdata[64:33]);
                check_field("is_empty",      WORD_W'(exp.empty),    WORD_W'(m_tdata[65]));
                check_field("at_first",      WORD_W'(exp.at_first), WORD_W'(m_tdata[66]));
                check_field("at_last",       WORD_W'(exp.at_last),  WORD_W'(m_tdata[67]));
                check_field("out_of_list",   WORD_W'(exp.off_list), WORD_W'(m_tdata[68]));
                check_field("entry_count",   WORD_W'(exp.count),
                            WORD_W'(m_tdata[69 +: COUNT_W]));
            end
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= FUNC_QUERY;
        cycle_count = 0;
        error_count = 0;
        idle_on     = 1'b1;
        head_slot   = '0;
        held_count  = '0;
        cursor_slot = '0;
        cursor_on   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_drain(12);
        test_pause_until_idle();
        test_back_to_back(400);
        test_random_mix(800);

        s_tvalid <= 1'b0;
        @(posedge clk);
        wait_results_drained();
        // the extra wait below catches any stray result
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
